// ===== hdl/heap_index_sort_core_defines.svh =====
// Assertion macros for the heap index sort core checker.
`ifndef HEAP_INDEX_SORT_CORE_DEFINES_SVH
`define HEAP_INDEX_SORT_CORE_DEFINES_SVH

// Clocked assertion, quiet while reset is held.
`define HIS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition that must never be seen.
`define HIS_NEVER(label, cond, msg) \
    `HIS_ASSERT(label, !(cond), msg)

`endif

// ===== hdl/his_pkg.sv =====
// Shared types and constants for the heap index sort core.
package his_pkg;

    localparam int S_KEY_BITS   = 32;
    localparam int POS_BITS     = 6;
    localparam int M_TDATA_BITS = 40;
    localparam int M_PAD_BITS   = M_TDATA_BITS - S_KEY_BITS - POS_BITS;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_SETUP,
        ST_SK_BEGIN,
        ST_SK_RIDX,
        ST_SK_RKEY,
        ST_LV_BEGIN,
        ST_LV_AIDX,
        ST_LV_AKEY,
        ST_LV_BIDX,
        ST_LV_BKEY,
        ST_LV_CMP,
        ST_LV_SWAP,
        ST_SK_END,
        ST_EX_R0,
        ST_EX_RI,
        ST_EX_W0,
        ST_EX_WI,
        ST_OUT_RIDX,
        ST_OUT_RKEY,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_WR,
        OP_BUILD_SETUP,
        OP_SK_BEGIN,
        OP_SK_RIDX,
        OP_SK_RKEY,
        OP_LV_BEGIN,
        OP_LV_AIDX,
        OP_LV_AKEY,
        OP_LV_BIDX,
        OP_LV_BKEY,
        OP_LV_CMP,
        OP_LV_SWAP,
        OP_BUILD_NEXT,
        OP_EXTRACT_SETUP,
        OP_EXTRACT_NEXT,
        OP_EX_R0,
        OP_EX_RI,
        OP_EX_W0,
        OP_EX_WI,
        OP_OUT_SETUP,
        OP_OUT_RIDX,
        OP_OUT_RKEY,
        OP_OUT_LOAD,
        OP_OUT_NEXT,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic no_child;   // 2*root beyond bottom of heap
        logic one_child;  // 2*root is the bottom slot
        logic cur_lt_ch;  // sinking element below chosen child
        logic init_last;  // j is the last loaded slot
        logic k_zero;
        logic n_one;
        logic i_one;
        logic out_fire;   // result request taken this cycle
        logic out_last;
    } dp_status_t;

endpackage

// ===== hdl/his_ram.sv =====
// Generic single write port RAM with registered read.
module his_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/his_ctrl.sv =====
// Sequencer for load, heap build, extraction and result output.
module his_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    input  his_pkg::dp_status_t status,
    output logic               s_tready,
    output his_pkg::dp_op_t    op
);
    import his_pkg::*;

    state_t state_reg, state_next;
    logic   extract_reg, extract_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            extract_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            extract_reg <= extract_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        extract_next = extract_reg;
        op           = OP_NONE;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op = OP_LOAD;
                    if (s_tlast) begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                op = OP_INIT_WR;
                if (status.init_last) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                op           = OP_BUILD_SETUP;
                extract_next = 1'b0;
                state_next   = ST_SK_BEGIN;
            end
            ST_SK_BEGIN: begin
                op         = OP_SK_BEGIN;
                state_next = status.no_child ? ST_SK_END : ST_SK_RIDX;
            end
            ST_SK_RIDX: begin
                op         = OP_SK_RIDX;
                state_next = ST_SK_RKEY;
            end
            ST_SK_RKEY: begin
                op         = OP_SK_RKEY;
                state_next = ST_LV_BEGIN;
            end
            ST_LV_BEGIN: begin
                op         = OP_LV_BEGIN;
                state_next = status.no_child ? ST_SK_END : ST_LV_AIDX;
            end
            ST_LV_AIDX: begin
                op         = OP_LV_AIDX;
                state_next = ST_LV_AKEY;
            end
            ST_LV_AKEY: begin
                op         = OP_LV_AKEY;
                state_next = status.one_child ? ST_LV_CMP : ST_LV_BIDX;
            end
            ST_LV_BIDX: begin
                op         = OP_LV_BIDX;
                state_next = ST_LV_BKEY;
            end
            ST_LV_BKEY: begin
                op         = OP_LV_BKEY;
                state_next = ST_LV_CMP;
            end
            ST_LV_CMP: begin
                op         = OP_LV_CMP;
                state_next = status.cur_lt_ch ? ST_LV_SWAP : ST_SK_END;
            end
            ST_LV_SWAP: begin
                op         = OP_LV_SWAP;
                state_next = ST_LV_BEGIN;
            end
            ST_SK_END: begin
                if (!extract_reg) begin
                    if (!status.k_zero) begin
                        op         = OP_BUILD_NEXT;
                        state_next = ST_SK_BEGIN;
                    end else if (status.n_one) begin
                        op         = OP_OUT_SETUP;
                        state_next = ST_OUT_RIDX;
                    end else begin
                        op           = OP_EXTRACT_SETUP;
                        extract_next = 1'b1;
                        state_next   = ST_EX_R0;
                    end
                end else if (status.i_one) begin
                    op         = OP_OUT_SETUP;
                    state_next = ST_OUT_RIDX;
                end else begin
                    op         = OP_EXTRACT_NEXT;
                    state_next = ST_EX_R0;
                end
            end
            ST_EX_R0: begin
                op         = OP_EX_R0;
                state_next = ST_EX_RI;
            end
            ST_EX_RI: begin
                op         = OP_EX_RI;
                state_next = ST_EX_W0;
            end
            ST_EX_W0: begin
                op         = OP_EX_W0;
                state_next = ST_EX_WI;
            end
            ST_EX_WI: begin
                op         = OP_EX_WI;
                state_next = ST_SK_BEGIN;
            end
            ST_OUT_RIDX: begin
                op         = OP_OUT_RIDX;
                state_next = ST_OUT_RKEY;
            end
            ST_OUT_RKEY: begin
                op         = OP_OUT_RKEY;
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
                op         = OP_OUT_LOAD;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (status.out_fire) begin
                    if (status.out_last) begin
                        op         = OP_FINISH;
                        state_next = ST_LOAD;
                    end else begin
                        op         = OP_OUT_NEXT;
                        state_next = ST_OUT_RIDX;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== hdl/his_dpath.sv =====
// Key and index stores, heap slot registers, comparator and result register.
module his_dpath #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  his_pkg::dp_op_t                 op,
    input  logic [his_pkg::S_KEY_BITS-1:0]  s_key,
    input  logic                            cfg_valid,
    input  logic                            cfg_data,
    input  logic                            m_tready,
    output his_pkg::dp_status_t             status,
    output logic                            m_valid,
    output logic [his_pkg::POS_BITS-1:0]    m_position,
    output logic [his_pkg::S_KEY_BITS-1:0]  m_key,
    output logic                            m_dropped,
    output logic                            m_last
);
    import his_pkg::*;

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    function automatic logic key_less(input logic [KEY_BITS-1:0] a,
                                      input logic [KEY_BITS-1:0] b,
                                      input logic                sgn);
        logic [KEY_BITS-1:0] flip;
        flip = KEY_BITS'(sgn) << (KEY_BITS - 1);
        return (a ^ flip) < (b ^ flip);
    endfunction

    // control state
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg, out_valid_next;
    logic          key_signed_reg;

    // working registers
    logic [IW-1:0]       j_reg, j_next;
    logic [IW-1:0]       root_reg, root_next;
    logic [IW-1:0]       bot_reg, bot_next;
    logic [IW-1:0]       k_reg, k_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [IW-1:0]       cur_idx_reg, cur_idx_next;
    logic [KEY_BITS-1:0] cur_key_reg, cur_key_next;
    logic [IW-1:0]       ch_idx_reg, ch_idx_next;
    logic [KEY_BITS-1:0] ch_key_reg, ch_key_next;
    logic [IW-1:0]       ch_slot_reg, ch_slot_next;
    logic [IW-1:0]       b_idx_reg, b_idx_next;
    logic [IW-1:0]       out_pos_reg, out_pos_next;
    logic [KEY_BITS-1:0] out_key_reg, out_key_next;
    logic                out_last_reg, out_last_next;

    // stores
    logic                idx_we;
    logic [IW-1:0]       idx_waddr, idx_wdata, idx_raddr, idx_rdata;
    logic                key_we;
    logic [IW-1:0]       key_waddr;
    logic [KEY_BITS-1:0] key_rdata;

    logic [IW:0] two_r, two_r1, bot_ext;
    logic        j_is_last, cur_lt_ch, b_gt_a, store_full;

    his_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_idx_ram (
        .aclk  (aclk),
        .we    (idx_we),
        .waddr (idx_waddr),
        .wdata (idx_wdata),
        .raddr (idx_raddr),
        .rdata (idx_rdata)
    );

    his_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ITEMS)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (KEY_BITS'(s_key)),
        .raddr (idx_rdata),
        .rdata (key_rdata)
    );

    assign two_r      = {root_reg, 1'b0};
    assign two_r1     = {root_reg, 1'b1};
    assign bot_ext    = (IW + 1)'(bot_reg);
    assign j_is_last  = (CW'(j_reg) + CW'(1)) == count_reg;
    assign cur_lt_ch  = key_less(cur_key_reg, ch_key_reg, key_signed_reg);
    assign b_gt_a     = key_less(ch_key_reg, key_rdata, key_signed_reg);
    assign store_full = count_reg >= CW'(MAX_ITEMS);

    assign key_we    = (op == OP_LOAD) && !store_full;
    assign key_waddr = IW'(count_reg);

    // index store address and write selection
    always_comb begin
        idx_we    = 1'b0;
        idx_waddr = root_reg;
        idx_wdata = ch_idx_reg;
        idx_raddr = root_reg;
        unique case (op)
            OP_INIT_WR: begin
                idx_we    = 1'b1;
                idx_waddr = j_reg;
                idx_wdata = j_reg;
            end
            OP_LV_BEGIN: idx_raddr = IW'(two_r);
            OP_LV_AKEY:  idx_raddr = IW'(two_r1);
            OP_LV_CMP: begin
                idx_we    = cur_lt_ch;
                idx_waddr = root_reg;
                idx_wdata = ch_idx_reg;
            end
            OP_LV_SWAP: begin
                idx_we    = 1'b1;
                idx_waddr = ch_slot_reg;
                idx_wdata = cur_idx_reg;
            end
            OP_EX_R0:    idx_raddr = '0;
            OP_EX_RI:    idx_raddr = i_reg;
            OP_EX_W0: begin
                idx_we    = 1'b1;
                idx_waddr = '0;
                idx_wdata = idx_rdata;
            end
            OP_EX_WI: begin
                idx_we    = 1'b1;
                idx_waddr = i_reg;
                idx_wdata = cur_idx_reg;
            end
            OP_OUT_RIDX: idx_raddr = j_reg;
            default: begin
                idx_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        j_next         = j_reg;
        root_next      = root_reg;
        bot_next       = bot_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        cur_idx_next   = cur_idx_reg;
        cur_key_next   = cur_key_reg;
        ch_idx_next    = ch_idx_reg;
        ch_key_next    = ch_key_reg;
        ch_slot_next   = ch_slot_reg;
        b_idx_next     = b_idx_reg;
        out_pos_next   = out_pos_reg;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (op)
            OP_LOAD: begin
                j_next = '0;
                if (store_full) begin
                    ovf_next = 1'b1;
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
            OP_INIT_WR:     j_next = j_reg + IW'(1);
            OP_BUILD_SETUP: begin
                k_next    = IW'(count_reg >> 1);
                root_next = IW'(count_reg >> 1);
                bot_next  = IW'(count_reg - CW'(1));
            end
            OP_SK_RIDX: cur_idx_next = idx_rdata;
            OP_SK_RKEY: cur_key_next = key_rdata;
            OP_LV_AIDX: ch_idx_next  = idx_rdata;
            OP_LV_AKEY: begin
                ch_key_next  = key_rdata;
                ch_slot_next = IW'(two_r);
            end
            OP_LV_BIDX: b_idx_next = idx_rdata;
            OP_LV_BKEY: begin
                // strict compare: right child wins only when larger
                if (b_gt_a) begin
                    ch_idx_next  = b_idx_reg;
                    ch_key_next  = key_rdata;
                    ch_slot_next = IW'(two_r1);
                end
            end
            OP_LV_SWAP:       root_next = ch_slot_reg;
            OP_BUILD_NEXT: begin
                k_next    = k_reg - IW'(1);
                root_next = k_reg - IW'(1);
            end
            OP_EXTRACT_SETUP: i_next = IW'(count_reg - CW'(1));
            OP_EXTRACT_NEXT:  i_next = i_reg - IW'(1);
            OP_EX_RI:         cur_idx_next = idx_rdata;
            OP_EX_WI: begin
                root_next = '0;
                bot_next  = i_reg - IW'(1);
            end
            OP_OUT_SETUP:     j_next = '0;
            OP_OUT_RKEY:      out_pos_next = idx_rdata;
            OP_OUT_LOAD: begin
                out_key_next   = key_rdata;
                out_last_next  = j_is_last;
                out_valid_next = 1'b1;
            end
            OP_OUT_NEXT:      j_next = j_reg + IW'(1);
            OP_FINISH: begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            default: begin
                j_next = j_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            key_signed_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                key_signed_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        j_reg        <= j_next;
        root_reg     <= root_next;
        bot_reg      <= bot_next;
        k_reg        <= k_next;
        i_reg        <= i_next;
        cur_idx_reg  <= cur_idx_next;
        cur_key_reg  <= cur_key_next;
        ch_idx_reg   <= ch_idx_next;
        ch_key_reg   <= ch_key_next;
        ch_slot_reg  <= ch_slot_next;
        b_idx_reg    <= b_idx_next;
        out_pos_reg  <= out_pos_next;
        out_key_reg  <= out_key_next;
        out_last_reg <= out_last_next;
    end

    assign status.no_child  = two_r > bot_ext;
    assign status.one_child = two_r == bot_ext;
    assign status.cur_lt_ch = cur_lt_ch;
    assign status.init_last = j_is_last;
    assign status.k_zero    = k_reg == '0;
    assign status.n_one     = count_reg == CW'(1);
    assign status.i_one     = i_reg == IW'(1);
    assign status.out_fire  = out_valid_reg && m_tready;
    assign status.out_last  = out_last_reg;

    assign m_valid    = out_valid_reg;
    assign m_position = POS_BITS'(out_pos_reg);
    assign m_key      = S_KEY_BITS'(out_key_reg);
    assign m_dropped  = ovf_reg;
    assign m_last     = out_last_reg;

endmodule

// ===== hdl/heap_index_sort_core.sv =====
// Keys load one per cycle; sorting n keys takes an index init of n slots, n/2+1 build sifts
// and n-1 extractions, each followed by a sift from the root; a sift stops at once at a leaf,
// else it reads one or both children per level (RAM read latency sets pace). Each result is
// read out, then held until taken; no key is taken while a set is busy.
// Reset (aresetn low, synchronous) clears the fill count, overflow flag, compare mode
// and output valid; both stores stay undefined and need no clearing pass.
module heap_index_sort_core #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [his_pkg::S_KEY_BITS-1:0]    s_tdata,   // [31:0] key
    input  logic                              s_tlast,   // last_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [his_pkg::M_TDATA_BITS-1:0]  m_tdata,   // [5:0] position, [37:6] sorted_key
    output logic                              m_tuser,   // [0] dropped
    output logic                              m_tlast,   // last
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data   // key_signed
);
    import his_pkg::*;

    dp_op_t                  op;
    dp_status_t              status;
    logic [POS_BITS-1:0]     position;
    logic [S_KEY_BITS-1:0]   sorted_key;

    his_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .status   (status),
        .s_tready (s_tready),
        .op       (op)
    );

    his_dpath #(.MAX_ITEMS(MAX_ITEMS), .KEY_BITS(KEY_BITS)) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .s_key      (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .m_tready   (m_tready),
        .status     (status),
        .m_valid    (m_tvalid),
        .m_position (position),
        .m_key      (sorted_key),
        .m_dropped  (m_tuser),
        .m_last     (m_tlast)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = {{M_PAD_BITS{1'b0}}, sorted_key, position};

endmodule

// ===== hdl/his_checker.sv =====
// Port-level checker for the heap index sort core, bound to the top level.
`include "heap_index_sort_core_defines.svh"

module his_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [his_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input logic                              m_tlast
);

    // loading and emitting never overlap
    `HIS_NEVER(a_no_load_while_out, s_tready && m_tvalid, "input open while result pending")

    // closing key of a set stops intake while it sorts
    `HIS_ASSERT(a_stop_after_last_in, s_tvalid && s_tready && s_tlast |=> !s_tready, "intake open after last key")

    // final result of a run leaves nothing behind
    `HIS_ASSERT(a_idle_after_last_out, m_tvalid && m_tready && m_tlast |=> !m_tvalid, "result after end of run")

    // stalled result request holds
    `HIS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind heap_index_sort_core his_checker u_his_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the heap index sort core: keys in, ranked positions out.
module tb_top;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 12;
    localparam int KB           = his_pkg::S_KEY_BITS;
    localparam int PB           = his_pkg::POS_BITS;
    localparam int DRAIN_GUARD  = 20000;

    typedef struct packed {
        logic [PB-1:0] position;
        logic [KB-1:0] sorted_key;
        logic          dropped;
        logic          last;
    } sort_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [KB-1:0]                   s_tdata;   // [31:0] key
    logic                            s_tlast;   // last_in
    logic                            m_tvalid;
    logic                            m_tready;
    logic [his_pkg::M_TDATA_BITS-1:0] m_tdata;  // [5:0] position, [37:6] sorted_key
    logic                            m_tuser;   // [0] dropped
    logic                            m_tlast;   // last
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic                            cfg_data;  // key_signed

    heap_index_sort_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // shadow copy of the sorter's state
    logic [KB-1:0] held_keys [CAPACITY];
    logic [PB-1:0] heap_pos  [CAPACITY];
    int            held_count    = 0;
    bit            held_overflow = 1'b0;
    bit            signed_mode   = 1'b0;

    sort_result_t  sorted_results[$];
    sort_result_t  want_r, got_r;

    int  err_count      = 0;
    int  keys_loaded    = 0;
    int  sets_sorted    = 0;
    int  overflow_sets  = 0;
    int  signed_sets    = 0;
    int  results_seen   = 0;
    bit  steady         = 1'b0;

    function automatic bit ranks_below(int a, int b);
        logic [KB-1:0] ka, kb;
        ka = held_keys[heap_pos[a]];
        kb = held_keys[heap_pos[b]];
        if (signed_mode) begin
            ka[KB-1] = ~ka[KB-1];
            kb[KB-1] = ~kb[KB-1];
        end
        return ka < kb;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [PB-1:0] t;
        t           = heap_pos[a];
        heap_pos[a] = heap_pos[b];
        heap_pos[b] = t;
    endfunction

    // children of node r sit at 2r and 2r+1, so node 0 may pick itself and stop
    function automatic void push_down(int root, int bottom);
        int child;
        while (root * 2 <= bottom) begin
            if (root * 2 == bottom)
                child = root * 2;
            else if (ranks_below(root * 2, root * 2 + 1))
                child = root * 2 + 1;
            else
                child = root * 2;
            if (!ranks_below(root, child))
                break;
            swap_slots(root, child);
            root = child;
        end
    endfunction

    function automatic void heapsort_held();
        sort_result_t r;
        int i, k;
        for (i = 0; i < held_count; i++)
            heap_pos[i] = PB'(i);
        for (k = held_count / 2; k >= 0; k--)
            push_down(k, held_count - 1);
        for (i = held_count - 1; i >= 1; i--) begin
            swap_slots(0, i);
            push_down(0, i - 1);
        end
        for (i = 0; i < held_count; i++) begin
            r.position   = heap_pos[i];
            r.sorted_key = held_keys[heap_pos[i]];
            r.dropped    = held_overflow;
            r.last       = (i == held_count - 1);
            sorted_results.push_back(r);
        end
        sets_sorted++;
        if (held_overflow)
            overflow_sets++;
        if (signed_mode)
            signed_sets++;
        held_count    = 0;
        held_overflow = 1'b0;
    endfunction

    function automatic void take_key(logic [KB-1:0] k, bit lst);
        if (held_count < CAPACITY) begin
            held_keys[held_count] = k;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        keys_loaded++;
        if (lst)
            heapsort_held();
    endfunction

    // watch accepted requests on the input and config channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                signed_mode = cfg_data;
            if (s_tvalid && s_tready)
                take_key(s_tdata, s_tlast);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_r = {m_tdata[PB-1:0], m_tdata[PB +: KB], m_tuser, m_tlast};
            results_seen++;
            if (sorted_results.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result pos=%0d key=%h dropped=%b last=%b",
                         $time, got_r.position, got_r.sorted_key, got_r.dropped, got_r.last);
            end else begin
                want_r = sorted_results.pop_front();
                if (got_r !== want_r) begin
                    err_count++;
                    $display("%0t: mismatch expected pos=%0d key=%h dropped=%b last=%b,",
                             $time, want_r.position, want_r.sorted_key, want_r.dropped,
                             want_r.last,
                             " got pos=%0d key=%h dropped=%b last=%b",
                             got_r.position, got_r.sorted_key, got_r.dropped, got_r.last);
                end
            end
        end
    end

    always @(posedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= 34);

    task automatic send_key(input logic [KB-1:0] k, input bit lst);
        while (!steady && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= k;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_set(input logic [KB-1:0] keys[$]);
        foreach (keys[i])
            send_key(keys[i], i == keys.size() - 1);
    endtask

    // block is idle once every result is back plus a short margin
    task automatic wait_idle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        // let the monitor queue the results of the closing key first
        @(posedge aclk);
        while (sorted_results.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_mode(input bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KB-1:0] rand_key();
        logic [KB-1:0] edges [4];
        edges = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);                       // many ties
            1: return {1'b1, 28'h0, 3'($urandom_range(0, 7))};    // around the sign flip
            2: return edges[$urandom_range(0, 3)];
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_set(input int n);
        logic [KB-1:0] keys[$];
        repeat (n) keys.push_back(rand_key());
        send_set(keys);
    endtask

    task automatic test_single_key();
        send_set('{32'hFFFF_FFFF});
        send_set('{32'h0000_0002, 32'h0000_0001});
        wait_idle();
    endtask

    task automatic test_extremes_both_modes();
        logic [KB-1:0] keys[$];
        keys = '{32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'h0000_0001, 32'hFFFF_FFFF};
        write_mode(1'b0);
        send_set(keys);
        wait_idle();
        write_mode(1'b1);
        send_set(keys);
        wait_idle();
        write_mode(1'b0);
    endtask

    task automatic test_equal_keys();
        send_set('{32'd5, 32'd5, 32'd3, 32'd5, 32'd5, 32'd9, 32'd5});
        wait_idle();
    endtask

    // exactly full store, sent and drained with no idling on either side
    task automatic test_full_set();
        steady = 1'b1;
        send_random_set(CAPACITY);
        wait_idle();
        steady = 1'b0;
    endtask

    // extra keys are discarded, the discarded last one still starts the sort
    task automatic test_overflow();
        write_mode(1'b1);
        send_random_set(CAPACITY + $urandom_range(1, 3));
        wait_idle();
        write_mode(1'b0);
    endtask

    task automatic test_random_sets();
        int sent, n;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
                                            : $urandom_range(1, 8);
            send_random_set(n);
            sent += n;
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                write_mode(1'($urandom_range(0, 1)));
            end
        end
        wait_idle();
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_key();
        test_extremes_both_modes();
        test_equal_keys();
        test_full_set();
        test_overflow();
        test_random_sets();

        repeat (50) @(posedge aclk);
        if (sorted_results.size() != 0) begin
            err_count += sorted_results.size();
            $display("%0t: %0d expected results never arrived, expected next pos=%0d key=%h",
                     $time, sorted_results.size(), sorted_results[0].position,
                     sorted_results[0].sorted_key);
        end
        $display("Run: %0d keys in %0d sets (%0d signed compare, %0d with dropped keys)",
                 keys_loaded, sets_sorted, signed_sets, overflow_sets);
        $display("Run: %0d sorted results compared under random back-pressure", results_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
